@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker of the blink pattern detector.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on clk, switched off while rst_n is low
`define BPD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion sampled on clk, active during reset as well
`define BPD_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/bpd_pkg.sv @@
// Package of the blink pattern detector: widths, reset values, phase and register codes.
// No dependencies.
`timescale 1ns / 1ps

package bpd_pkg;

  localparam int TimeW    = 32;
  localparam int PeriodW  = 14;
  localparam int TolW     = 10;
  localparam int PhaseW   = 4;
  localparam int CfgDataW = 14;
  localparam int CfgIdxW  = 1;

  localparam logic [PeriodW-1:0] PeriodRst = 14'd500;
  localparam logic [TolW-1:0]    TolRst    = 10'd100;

  typedef enum logic [PhaseW-1:0] {
    PH_START     = 4'd0,
    PH_BKG_RESET = 4'd1,
    PH_SEARCH    = 4'd2,
    PH_OFF1      = 4'd3,
    PH_ON1       = 4'd4,
    PH_OFF2      = 4'd5,
    PH_ON2       = 4'd6,
    PH_OFF3_CAL  = 4'd7,
    PH_OFF3      = 4'd8,
    PH_ON3       = 4'd9,
    PH_FOUND     = 4'd10
  } phase_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PERIOD = 1'b0,
    CFG_TOL    = 1'b1
  } cfg_idx_t;

  function automatic phase_t phase_inc(phase_t p);
    logic [PhaseW-1:0] v;
    v = PhaseW'(p) + PhaseW'(1);
    return phase_t'(v);
  endfunction

endpackage

@@ rtl/bpd_ifs.sv @@
// Valid/ready channel interfaces of the blink pattern detector: frame input and result output.
// Depends on bpd_pkg.
`timescale 1ns / 1ps

interface bpd_in_if;
  logic                        valid;
  logic                        ready;
  logic [bpd_pkg::TimeW-1:0]   frame_time_ms;
  logic                        target_seen;

  modport source (output valid, output frame_time_ms, output target_seen, input ready);
  modport sink   (input valid, input frame_time_ms, input target_seen, output ready);
endinterface

interface bpd_out_if;
  logic                        valid;
  logic                        ready;
  logic [bpd_pkg::PhaseW-1:0]  phase;
  logic                        calib_request;
  logic                        drone_found;
  logic                        past_search;

  modport source (output valid, output phase, output calib_request, output drone_found,
                  output past_search, input ready);
  modport sink   (input valid, input phase, input calib_request, input drone_found,
                  input past_search, output ready);
endinterface

@@ rtl/blink_pattern_detector.sv @@
// Top level of the blink pattern detector: input register, phase update, result register.
// Depends on bpd_pkg and the channel interfaces in bpd_ifs.sv.
// An accepted transaction is held in the input register, then its result in the result register.
// Throughput: one transaction per cycle unless the result channel stalls; the phase and
//   edge-time update is a subtract and three compares against period +/- tolerance, combinational.
// Reset (synchronous, rst_n low): both stages empty, phase start, edge time zero,
//   period 500 ms, tolerance 100 ms.
`timescale 1ns / 1ps

module blink_pattern_detector (
  input  logic                           clk,
  input  logic                           rst_n,
  bpd_in_if.sink                         in_chan,
  bpd_out_if.source                      out_chan,
  input  logic                           cfg_we,
  input  logic [bpd_pkg::CfgIdxW-1:0]    cfg_idx,
  input  logic [bpd_pkg::CfgDataW-1:0]   cfg_wdata
);

  logic [bpd_pkg::PeriodW-1:0] period_r;
  logic [bpd_pkg::TolW-1:0]    tol_r;

  logic                        in_v_r;
  logic [bpd_pkg::TimeW-1:0]   in_time_r;
  logic                        in_seen_r;
  logic                        in_adv;

  bpd_pkg::phase_t             phase_r, phase_nxt;
  logic [bpd_pkg::TimeW-1:0]   edge_r, edge_nxt;
  logic                        calib_nxt;

  logic                        out_v_r;
  bpd_pkg::phase_t             out_phase_r;
  logic                        out_calib_r;
  logic                        out_found_r;
  logic                        out_past_r;

  logic [bpd_pkg::TimeW-1:0]   elapsed;
  logic [bpd_pkg::PeriodW:0]   hi;
  logic [bpd_pkg::PeriodW-1:0] lo;
  logic                        lo_neg;
  logic                        in_win;
  logic                        late;
  logic                        judge;
  logic                        want;
  bpd_pkg::phase_t             base;

  always_comb begin
    in_adv        = in_v_r && (!out_v_r || out_chan.ready);
    in_chan.ready = !in_v_r || in_adv;
  end

  always_comb begin
    elapsed = in_time_r - edge_r;
    hi      = {1'b0, period_r} + (bpd_pkg::PeriodW+1)'(tol_r);
    lo_neg  = bpd_pkg::PeriodW'(tol_r) > period_r;
    lo      = period_r - bpd_pkg::PeriodW'(tol_r);
    in_win  = (lo_neg || (elapsed > bpd_pkg::TimeW'(lo))) && (elapsed < bpd_pkg::TimeW'(hi));
    late    = elapsed > bpd_pkg::TimeW'(hi);
  end

  always_comb begin
    phase_nxt = phase_r;
    edge_nxt  = edge_r;
    calib_nxt = 1'b0;
    judge     = 1'b0;
    want      = 1'b0;
    base      = phase_r;
    unique case (phase_r)
      bpd_pkg::PH_START:     phase_nxt = bpd_pkg::PH_BKG_RESET;
      bpd_pkg::PH_BKG_RESET: phase_nxt = bpd_pkg::PH_SEARCH;
      bpd_pkg::PH_SEARCH: begin
        if (in_seen_r) begin
          phase_nxt = bpd_pkg::PH_OFF1;
          edge_nxt  = in_time_r;
        end
      end
      bpd_pkg::PH_OFF1, bpd_pkg::PH_OFF2, bpd_pkg::PH_OFF3: begin
        judge = 1'b1;
        want  = !in_seen_r;
      end
      bpd_pkg::PH_ON1, bpd_pkg::PH_ON2, bpd_pkg::PH_ON3: begin
        judge = 1'b1;
        want  = in_seen_r;
      end
      bpd_pkg::PH_OFF3_CAL: begin
        judge     = 1'b1;
        want      = !in_seen_r;
        base      = bpd_pkg::PH_OFF3;
        calib_nxt = 1'b1;
      end
      bpd_pkg::PH_FOUND:     phase_nxt = bpd_pkg::PH_FOUND;
      default:               phase_nxt = bpd_pkg::PH_START;
    endcase
    if (judge) begin
      priority if (want && in_win) begin
        phase_nxt = bpd_pkg::phase_inc(base);
        edge_nxt  = in_time_r;
      end else if (want || late) begin
        phase_nxt = bpd_pkg::PH_SEARCH;
      end else begin
        phase_nxt = base;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= bpd_pkg::PeriodRst;
      tol_r    <= bpd_pkg::TolRst;
    end else if (cfg_we) begin
      unique case (bpd_pkg::cfg_idx_t'(cfg_idx))
        bpd_pkg::CFG_PERIOD: period_r <= cfg_wdata;
        bpd_pkg::CFG_TOL:    tol_r    <= cfg_wdata[bpd_pkg::TolW-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_v_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      in_time_r <= in_chan.frame_time_ms;
      in_seen_r <= in_chan.target_seen;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= bpd_pkg::PH_START;
      edge_r  <= '0;
      out_v_r <= 1'b0;
    end else if (in_adv) begin
      phase_r <= phase_nxt;
      edge_r  <= edge_nxt;
      out_v_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_adv) begin
      out_phase_r <= phase_nxt;
      out_calib_r <= calib_nxt;
      out_found_r <= (phase_nxt == bpd_pkg::PH_FOUND);
      out_past_r  <= (phase_nxt > bpd_pkg::PH_SEARCH);
    end
  end

  assign out_chan.valid         = out_v_r;
  assign out_chan.phase         = out_phase_r;
  assign out_chan.calib_request = out_calib_r;
  assign out_chan.drone_found   = out_found_r;
  assign out_chan.past_search   = out_past_r;

endmodule

@@ rtl/bpd_checker.sv @@
// Port-level checker of the blink pattern detector and its bind to the top level.
// Depends on bpd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bpd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [bpd_pkg::PhaseW-1:0]  out_phase,
  input logic                        calib_request,
  input logic                        drone_found,
  input logic                        past_search
);

  `BPD_ASSERT_NR(a_rst_empty, clk, !rst_n |=> !out_valid, "result valid right after reset")
  `BPD_ASSERT(a_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_phase) && $stable(calib_request), "stalled transaction changed")
  `BPD_ASSERT(a_found, clk, rst_n, out_valid && drone_found |-> past_search && out_phase == bpd_pkg::PH_FOUND, "found flag without found phase")
  `BPD_ASSERT(a_past, clk, rst_n, out_valid |-> past_search == (out_phase > bpd_pkg::PH_SEARCH), "past_search disagrees with phase")
  `BPD_ASSERT(a_calib, clk, rst_n, out_valid && calib_request |-> out_phase == bpd_pkg::PH_OFF3 || out_phase == bpd_pkg::PH_ON3 || out_phase == bpd_pkg::PH_SEARCH, "calibration request from wrong phase")

endmodule

bind blink_pattern_detector bpd_checker u_bpd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .out_phase     (out_chan.phase),
  .calib_request (out_chan.calib_request),
  .drone_found   (out_chan.drone_found),
  .past_search   (out_chan.past_search)
);
